// File: hw/rtl/dss_pkg.sv
`default_nettype none

package dss_pkg;

  // Longest delimiter the block is built for, and the depth of the pending window.
  localparam int MaxDelimLen = 8;
  localparam int WinDepth    = 8;
  localparam int MaxLen      = (MaxDelimLen < WinDepth) ? MaxDelimLen : WinDepth;

  localparam int CharW  = 8;
  localparam int CountW = $clog2(WinDepth);

  // Configuration register indexes.
  localparam logic [1:0] CfgDelimBytes = 2'd0;
  localparam logic [1:0] CfgDelimLen   = 2'd1;
  localparam logic [1:0] CfgKeepEmpty  = 2'd2;

  // Input item kinds.
  localparam logic KindChar      = 1'b0;
  localparam logic KindEndString = 1'b1;

  typedef logic [CharW-1:0]  char_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [CountW:0]   num_t;

  typedef enum logic [1:0] {
    OutChar    = 2'd0,
    OutEndTok  = 2'd1,
    OutEndList = 2'd2
  } out_kind_e;

  // Every result caused by one request: leading token characters, then an
  // optional end of token and an optional end of list.
  typedef struct packed {
    char_t [WinDepth-1:0] chars;
    num_t                 nchar;
    logic                 eot;
    logic                 eol;
  } batch_t;

  // Splitter state carried from one request to the next.
  typedef struct packed {
    char_t [WinDepth-1:0] win;
    count_t               count;
    logic                 has_chars;
  } split_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/dss_match.sv
`default_nettype none

module dss_match import dss_pkg::*; (
  input  logic                     kind_i,
  input  char_t                    ch_i,
  input  split_state_t             state_i,
  input  logic [WinDepth*CharW-1:0] delim_bytes_i,
  input  logic [3:0]               delim_len_i,
  input  logic                     keep_empty_i,
  output batch_t                   batch_o,
  output split_state_t             state_o
);

  logic [3:0]                          eff_len;
  char_t [WinDepth-1:0]                wn;
  char_t [WinDepth-1:0]                wsh;
  char_t [WinDepth-1:0]                dch;
  logic  [WinDepth-1:0][WinDepth-1:0]  eq;
  logic  [WinDepth:0]                  viable;
  num_t                                pop;
  num_t                                rem;
  logic                                has_new;

  // Delimiter length: zero acts as one, anything longer is clamped.
  always_comb begin
    eff_len = delim_len_i;
    if (eff_len == 4'd0) begin
      eff_len = 4'd1;
    end
    if (eff_len > 4'(MaxLen)) begin
      eff_len = 4'(MaxLen);
    end
  end

  // Window with the new character written behind the held ones.
  always_comb begin
    for (int j = 0; j < WinDepth; j++) begin
      dch[j] = delim_bytes_i[j*CharW +: CharW];
      wn[j]  = (count_t'(j) == state_i.count) ? ch_i : state_i.win[j];
    end
  end

  always_comb begin
    for (int j = 0; j < WinDepth; j++) begin
      for (int i = 0; i < WinDepth; i++) begin
        eq[j][i] = (wn[j] == dch[i]);
      end
    end
  end

  // viable[k]: after dropping k leading characters, what is left is a prefix
  // of the delimiter.
  always_comb begin
    int   l;
    logic ok;
    l  = 0;
    ok = 1'b0;
    for (int k = 0; k <= WinDepth; k++) begin
      l  = int'(state_i.count) + 1 - k;
      ok = (l >= 0) && (l <= int'(eff_len));
      for (int i = 0; i < WinDepth; i++) begin
        if (i < l && k + i < WinDepth) begin
          ok = ok && eq[k+i][i];
        end
      end
      viable[k] = ok;
    end
  end

  // The smallest such k is the number of characters released.
  always_comb begin
    pop = num_t'(WinDepth);
    for (int k = WinDepth; k >= 0; k--) begin
      if (viable[k]) begin
        pop = num_t'(k);
      end
    end
  end

  assign rem     = num_t'(state_i.count) + num_t'(1) - pop;
  assign has_new = state_i.has_chars | (pop != '0);

  always_comb begin
    num_t src;
    src = '0;
    for (int j = 0; j < WinDepth; j++) begin
      src    = num_t'(j) + pop;
      wsh[j] = (src < num_t'(WinDepth)) ? wn[src[CountW-1:0]] : '0;
    end
  end

  always_comb begin
    batch_o = '0;
    state_o = state_i;
    if (kind_i == KindEndString) begin
      batch_o.chars     = state_i.win;
      batch_o.nchar     = num_t'(state_i.count);
      batch_o.eot       = state_i.has_chars | (state_i.count != '0) | keep_empty_i;
      batch_o.eol       = 1'b1;
      state_o.count     = '0;
      state_o.has_chars = 1'b0;
    end else begin
      batch_o.chars = wn;
      batch_o.nchar = pop;
      state_o.win   = wsh;
      if (4'(rem) == eff_len) begin
        batch_o.eot       = has_new | keep_empty_i;
        state_o.count     = '0;
        state_o.has_chars = 1'b0;
      end else begin
        state_o.count     = rem[CountW-1:0];
        state_o.has_chars = has_new;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dss_result_buf.sv
`default_nettype none

module dss_result_buf import dss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  batch_t    batch_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_kind_e out_kind_o,
  output char_t     out_value_o,
  output logic      final_result_o,
  output logic      free_o
);

  logic     valid_q;
  batch_t   batch_q;
  num_t     pos_q;
  num_t     pos_d;
  num_t     total;
  logic     last;

  assign total = batch_q.nchar + num_t'(batch_q.eot) + num_t'(batch_q.eol);
  assign last  = (pos_q == total - num_t'(1));
  assign free_o = !valid_q || (out_ready_i && last);

  assign out_valid_o    = valid_q;
  assign final_result_o = last;

  always_comb begin
    out_value_o = '0;
    if (pos_q < batch_q.nchar) begin
      out_kind_o  = OutChar;
      out_value_o = batch_q.chars[pos_q[CountW-1:0]];
    end else if (pos_q == batch_q.nchar && batch_q.eot) begin
      out_kind_o = OutEndTok;
    end else begin
      out_kind_o = OutEndList;
    end
  end

  assign pos_d = load_i ? '0 : (pos_q + num_t'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      pos_q   <= pos_d;
    end else if (valid_q && out_ready_i) begin
      valid_q <= !last;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      batch_q <= batch_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/delimiter_string_splitter.sv
// Splits a character stream on a delimiter of one to eight characters, one
// character per request, leftmost match first, with no overlapping matches.
// Each result is a token character, an end of token or an end of list, and
// final_result_o marks the last result caused by a request. A request is
// registered at the input, judged against the delimiter by a parallel window
// compare and handed to the result buffer, whose register offers its results.
// The result buffer sends one result per cycle while out_ready_i is high, which
// sets the rate: a request that causes n results (0 to 9) holds the buffer until
// its last result is taken, and one that causes none passes straight through.
// A character that releases at most one result therefore keeps a steady stream
// at one request per cycle while out_ready_i is high. Configuration is written
// through cfg_we_i / cfg_index_i / cfg_data_i and must only change while the
// block is idle.
`default_nettype none

module delimiter_string_splitter import dss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_value_o,
  output logic        final_result_o
);

  // Configuration registers, reset to a single '|' delimiter.
  logic [63:0] delim_bytes_q;
  logic [3:0]  delim_len_q;
  logic        keep_empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_bytes_q <= 64'd124;
      delim_len_q   <= 4'd1;
      keep_empty_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDelimBytes: delim_bytes_q <= cfg_data_i;
        CfgDelimLen:   delim_len_q   <= cfg_data_i[3:0];
        CfgKeepEmpty:  keep_empty_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register: holds one request until the buffer can take its results.
  logic  in_valid_q;
  logic  in_kind_q;
  char_t in_char_q;
  logic  advance;

  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_kind_q <= kind_i;
      in_char_q <= data_value_i;
    end
  end

  // Splitter state. The window contents need no reset: only the first
  // pending-count entries are ever looked at.
  char_t [WinDepth-1:0] win_q;
  count_t               count_q;
  logic                 has_chars_q;
  split_state_t         state_cur;
  split_state_t         state_d;
  batch_t               batch;
  logic                 no_results;
  logic                 buf_free;
  out_kind_e            out_kind;

  assign state_cur.win       = win_q;
  assign state_cur.count     = count_q;
  assign state_cur.has_chars = has_chars_q;

  dss_match u_match (
    .kind_i        (in_kind_q),
    .ch_i          (in_char_q),
    .state_i       (state_cur),
    .delim_bytes_i (delim_bytes_q),
    .delim_len_i   (delim_len_q),
    .keep_empty_i  (keep_empty_q),
    .batch_o       (batch),
    .state_o       (state_d)
  );

  // A request that releases nothing only updates the state and never waits.
  assign no_results = (batch.nchar == '0) && !batch.eot && !batch.eol;
  assign advance    = in_valid_q && (no_results || buf_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      has_chars_q <= 1'b0;
    end else if (advance) begin
      count_q     <= state_d.count;
      has_chars_q <= state_d.has_chars;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      win_q <= state_d.win;
    end
  end

  dss_result_buf u_result_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance && !no_results),
    .batch_i        (batch),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_kind_o     (out_kind),
    .out_value_o    (out_value_o),
    .final_result_o (final_result_o),
    .free_o         (buf_free)
  );

  assign out_kind_o = out_kind;

endmodule

`default_nettype wire

// File: hw/rtl/dss_checker.sv
`default_nettype none

module dss_checker import dss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [1:0]  out_kind_o,
  input  logic [7:0]  out_value_o,
  input  logic        final_result_o
);

  // Only the three defined result kinds are ever shown.
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kind_o == OutChar || out_kind_o == OutEndTok ||
                     out_kind_o == OutEndList))
    else $error("undefined result kind");

  // Markers carry a zero value.
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o != OutChar) |-> (out_value_o == 8'd0))
    else $error("marker with non-zero value");

  // End of list always closes the results of its request.
  a_eol_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == OutEndList) |-> final_result_o)
    else $error("end of list not marked final");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_kind_o) && $stable(out_value_o) &&
       $stable(final_result_o)))
    else $error("stalled result changed");

endmodule

bind delimiter_string_splitter dss_checker u_dss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_kind_o     (out_kind_o),
  .out_value_o    (out_value_o),
  .final_result_o (final_result_o)
);

`default_nettype wire
